FILE: rtl/imgconv_pkg.sv
package imgconv_pkg;

  localparam int PIX_W     = 16;
  localparam int COEF_W    = 8;
  localparam int NUM_COEFS = 25;
  localparam int ACC_W     = 24;
  localparam int SCALE_W   = 32;
  localparam int OFFS_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int HALF_W    = 2;
  localparam int TAP_W     = 6;
  localparam int CH_W      = 8;

  localparam logic [CH_W-1:0] GRAY_MAX  = 8'd255;
  localparam logic [CH_W-1:0] RED_MAX   = 8'd31;
  localparam logic [CH_W-1:0] GREEN_MAX = 8'd63;
  localparam logic [CH_W-1:0] BLUE_MAX  = 8'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_COEF0  = 3'd1,
    REG_COEF1  = 3'd2,
    REG_COEF2  = 3'd3,
    REG_COEF3  = 3'd4,
    REG_SCALE  = 3'd5,
    REG_OFFSET = 3'd6,
    REG_FRAME  = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] acc;
    logic [CH_W-1:0]         maxv;
  } scale_req_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [4*CFG_W-1:0] words,
                                                      input logic [TAP_W-1:0] t);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (t < TAP_W'(NUM_COEFS)) begin
      c = words[{t[4:0], 3'b000} +: COEF_W];
    end
    return c;
  endfunction

endpackage

FILE: rtl/image_convolution_scale_clamp.sv
// Channel   Handshake               Payload
// s_        s_tvalid / s_tready     s_tdata pixel_in, s_tuser cmd
// m_        m_tvalid / m_tready     m_tdata pixel_out, m_tlast frame_end
// cfg_      cfg_wr_en               cfg_index, cfg_wdata
// One item is handled at a time. An item that neither stores a pixel nor gives a result
// goes back to idle after the position check (or after the size check for an empty
// frame); a push that only stores waits for the line store address, which comes from a
// three-stage modulo unit. An item that gives a result walks the kernel taps, read one
// per cycle from the line store, then scales and clamps each channel in turn.
// Reset is synchronous; the line store is not cleared. A result waits in the output
// register while the next item is taken; the result after it waits for that one to leave.
module image_convolution_scale_clamp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_HALF   = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [imgconv_pkg::PIX_W-1:0]         s_tdata,   // pixel_in
  input  logic [0:0]                            s_tuser,   // cmd
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [imgconv_pkg::PIX_W-1:0]         m_tdata,   // pixel_out
  output logic                                  m_tlast,
  input  logic                                  cfg_wr_en,
  input  logic [imgconv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imgconv_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DEPTH = 2 * (MAX_HALF * MAX_WIDTH + MAX_HALF) + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW    = AW + 2;
  localparam int YW    = RW + 4;
  localparam int XW    = CW + 4;
  localparam int HW    = imgconv_pkg::HALF_W;
  localparam int SPW   = 3;
  localparam int TPW   = imgconv_pkg::TAP_W;
  localparam int AC    = imgconv_pkg::ACC_W;
  localparam int CHW   = imgconv_pkg::CH_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_POS   = 8'b0000_0010,
    S_CHK   = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_TAP   = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_FWAIT = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [2:0]                                  mode;
  logic [4*imgconv_pkg::CFG_W-1:0]             coef_words;
  logic signed [imgconv_pkg::SCALE_W-1:0]      scale;
  logic signed [imgconv_pkg::OFFS_W-1:0]       offset;
  logic [31:0]                                 frame_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 3'd2;
      coef_words <= '0;
      scale      <= 32'sd65536;
      offset     <= '0;
      frame_size <= '0;
    end else if (cfg_wr_en) begin
      unique case (imgconv_pkg::cfg_reg_t'(cfg_index))
        imgconv_pkg::REG_MODE:   mode                <= cfg_wdata[2:0];
        imgconv_pkg::REG_COEF0:  coef_words[63:0]    <= cfg_wdata;
        imgconv_pkg::REG_COEF1:  coef_words[127:64]  <= cfg_wdata;
        imgconv_pkg::REG_COEF2:  coef_words[191:128] <= cfg_wdata;
        imgconv_pkg::REG_COEF3:  coef_words[255:192] <= cfg_wdata;
        imgconv_pkg::REG_SCALE:  scale               <= cfg_wdata[31:0];
        imgconv_pkg::REG_OFFSET: offset              <= cfg_wdata[15:0];
        imgconv_pkg::REG_FRAME:  frame_size          <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [HW-1:0] half_eff;
  logic          rgb;

  always_comb begin
    w_eff    = (frame_size[15:0] > 16'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : frame_size[CW-1:0];
    h_eff    = (frame_size[31:16] > 16'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : frame_size[RW+15:16];
    half_eff = (mode[2:1] > HW'(MAX_HALF)) ? HW'(MAX_HALF) : mode[2:1];
    rgb      = mode[0];
  end

  imgconv_pkg::cmd_t              cmd_q;
  logic [imgconv_pkg::PIX_W-1:0]  pix_q;
  logic [CW-1:0]                  in_col;
  logic [RW-1:0]                  in_row;
  logic [CW-1:0]                  out_col;
  logic [RW-1:0]                  out_row;
  logic                           clr1;
  logic [LW-1:0]                  rxm;
  logic [LW-1:0]                  oxm;
  logic [LW-1:0]                  total;
  logic                           wr_pend;
  logic                           emit;
  logic                           frame_last;

  // Position check of the stored counters against the current frame size.
  logic [LW-1:0] rx_c;
  logic [LW-1:0] ox_c;
  logic          bad_c;
  logic          clr_c;
  logic [LW:0]   lag_c;
  logic          push_ok;
  logic          emit_c;
  logic          go_c;

  always_comb begin
    rx_c  = clr1 ? '0 : rxm;
    ox_c  = clr1 ? '0 : oxm;
    bad_c = (rx_c > total) || (ox_c >= total) || (ox_c > rx_c);
    if (bad_c) begin
      rx_c = '0;
      ox_c = '0;
    end
    clr_c   = clr1 | bad_c;
    lag_c   = (LW + 1)'(half_eff) * (LW + 1)'(w_eff) + (LW + 1)'(half_eff);
    push_ok = (cmd_q == imgconv_pkg::CMD_PUSH) && (rx_c < total);
    if (push_ok) begin
      emit_c = ((LW + 1)'(rx_c) + 1'b1) > ((LW + 1)'(ox_c) + lag_c);
    end else begin
      emit_c = (cmd_q == imgconv_pkg::CMD_DRAIN) && (rx_c == total);
    end
    go_c = push_ok || emit_c;
  end

  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] wr_mod;
  logic [AW-1:0] ox_mod;

  assign mod_start = (state == S_CHK) && go_c;

  imgconv_mod #(.VW(LW), .DIV(DEPTH), .AW(AW)) u_mod_wr (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (rx_c),
    .done   (mod_done),
    .result (wr_mod)
  );

  imgconv_mod #(.VW(LW), .DIV(DEPTH), .AW(AW)) u_mod_rd (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (ox_c),
    .done   (),
    .result (ox_mod)
  );

  // Tap walk state.
  logic [AW-1:0]            base_mod;
  logic [SPW-1:0]           tap_r;
  logic [SPW-1:0]           tap_c;
  logic [TPW-1:0]           tap_t;
  logic signed [OW-1:0]     rowoff;
  logic                     issuing;
  logic                     d_valid;
  logic                     d_inf;
  logic signed [7:0]        d_coef;
  logic signed [AC-1:0]     acc [3];
  logic [1:0]               ch_i;
  logic [CHW-1:0]           chres [3];

  logic [SPW-1:0]           span_m1;
  logic signed [YW-1:0]     yy;
  logic signed [XW-1:0]     xx;
  logic                     inf;
  logic signed [OW-1:0]     a_sum;
  logic [AW-1:0]            rd_addr;
  logic                     rd_en;
  logic                     wr_en;
  logic [imgconv_pkg::PIX_W-1:0] rd_data;

  always_comb begin
    span_m1 = {half_eff, 1'b0};
    yy  = $signed(YW'(out_row)) + $signed(YW'(tap_r)) - $signed(YW'(half_eff));
    xx  = $signed(XW'(out_col)) + $signed(XW'(tap_c)) - $signed(XW'(half_eff));
    inf = (yy >= 0) && (yy < $signed(YW'(h_eff))) && (xx >= 0) && (xx < $signed(XW'(w_eff)));
    a_sum = $signed(OW'(base_mod)) + rowoff + $signed(OW'(tap_c)) - $signed(OW'(half_eff));
    if (a_sum < 0) begin
      a_sum = a_sum + $signed(OW'(DEPTH));
    end else if (a_sum >= $signed(OW'(DEPTH))) begin
      a_sum = a_sum - $signed(OW'(DEPTH));
    end
    rd_addr = a_sum[AW-1:0];
    rd_en   = (state == S_TAP) && issuing && inf;
    wr_en   = (state == S_MOD) && mod_done && wr_pend;
  end

  imgconv_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_mod),
    .wr_data (pix_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [CHW-1:0] px [3];
  always_comb begin
    px[0] = rgb ? CHW'(rd_data[15:11]) : rd_data[7:0];
    px[1] = CHW'(rd_data[10:5]);
    px[2] = CHW'(rd_data[4:0]);
  end

  imgconv_pkg::scale_req_t req;
  logic                    res_valid;
  logic [CHW-1:0]          res;
  logic                    last_ch;

  always_comb begin
    req.valid = (state == S_FIN);
    req.acc   = acc[ch_i];
    if (!rgb) begin
      req.maxv = imgconv_pkg::GRAY_MAX;
    end else if (ch_i == 2'd1) begin
      req.maxv = imgconv_pkg::GREEN_MAX;
    end else if (ch_i == 2'd0) begin
      req.maxv = imgconv_pkg::RED_MAX;
    end else begin
      req.maxv = imgconv_pkg::BLUE_MAX;
    end
    last_ch = rgb ? (ch_i == 2'd2) : (ch_i == 2'd0);
  end

  imgconv_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .scale     (scale),
    .offset    (offset),
    .res_valid (res_valid),
    .res       (res)
  );

  logic out_load;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      m_tvalid <= 1'b0;
      issuing  <= 1'b0;
      d_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      d_valid <= (state == S_TAP) && issuing;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q <= imgconv_pkg::cmd_t'(s_tuser[0]);
            pix_q <= s_tdata;
            state <= S_POS;
          end
        end
        S_POS: begin
          if (w_eff == '0 || h_eff == '0) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
            state   <= S_IDLE;
          end else begin
            clr1  <= (in_col >= w_eff) || (out_col >= w_eff) || (in_row > h_eff) ||
                     (out_row >= h_eff);
            rxm   <= LW'(LW'(in_row) * LW'(w_eff) + LW'(in_col));
            oxm   <= LW'(LW'(out_row) * LW'(w_eff) + LW'(out_col));
            total <= LW'(LW'(h_eff) * LW'(w_eff));
            state <= S_CHK;
          end
        end
        S_CHK: begin
          wr_pend    <= push_ok;
          emit       <= emit_c;
          frame_last <= ((LW + 1)'(ox_c) + 1'b1) == (LW + 1)'(total);
          if (clr_c) begin
            out_col <= '0;
            out_row <= '0;
          end
          if (push_ok) begin
            if ((CW + 1)'(clr_c ? '0 : in_col) + 1'b1 >= (CW + 1)'(w_eff)) begin
              in_col <= '0;
              in_row <= (clr_c ? '0 : in_row) + 1'b1;
            end else begin
              in_col <= (clr_c ? '0 : in_col) + 1'b1;
              in_row <= clr_c ? '0 : in_row;
            end
          end else if (clr_c) begin
            in_col <= '0;
            in_row <= '0;
          end
          state <= go_c ? S_MOD : S_IDLE;
        end
        S_MOD: begin
          if (mod_done) begin
            base_mod <= ox_mod;
            tap_r    <= '0;
            tap_c    <= '0;
            tap_t    <= '0;
            rowoff   <= -$signed(OW'(OW'(half_eff) * OW'(w_eff)));
            issuing  <= 1'b1;
            acc[0]   <= '0;
            acc[1]   <= '0;
            acc[2]   <= '0;
            ch_i     <= '0;
            state    <= emit ? S_TAP : S_IDLE;
          end
        end
        S_TAP: begin
          if (issuing) begin
            d_inf  <= inf;
            d_coef <= imgconv_pkg::coef_at(coef_words, tap_t);
            tap_t  <= tap_t + 1'b1;
            if (tap_c == span_m1) begin
              tap_c  <= '0;
              tap_r  <= tap_r + 1'b1;
              rowoff <= rowoff + $signed(OW'(w_eff));
              if (tap_r == span_m1) begin
                issuing <= 1'b0;
              end
            end else begin
              tap_c <= tap_c + 1'b1;
            end
          end
          if (d_valid && d_inf) begin
            for (int i = 0; i < 3; i++) begin
              acc[i] <= acc[i] + AC'(d_coef * $signed({1'b0, px[i]}));
            end
          end
          if (!issuing && !d_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (res_valid) begin
            chres[ch_i] <= res;
            if (last_ch) begin
              state <= S_OUT;
            end else begin
              ch_i  <= ch_i + 1'b1;
              state <= S_FIN;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tlast  <= frame_last;
            m_tdata  <= rgb ? {chres[0][4:0], chres[1][5:0], chres[2][4:0]}
                            : {8'h00, chres[0]};
            if (frame_last) begin
              in_col  <= '0;
              in_row  <= '0;
              out_col <= '0;
              out_row <= '0;
            end else if ((CW + 1)'(out_col) + 1'b1 >= (CW + 1)'(w_eff)) begin
              out_col <= '0;
              out_row <= out_row + 1'b1;
            end else begin
              out_col <= out_col + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ((AW + 1)'(rd_addr) < (AW + 1)'(DEPTH)))
    else $error("line store read address beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in work");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && frame_last) |=>
      (in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0))
    else $error("positions not cleared after last item of frame");

  a_write_once: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !wr_en)
    else $error("line store written twice for one item");

endmodule

FILE: rtl/imgconv_store.sv
module imgconv_store #(
  parameter int DEPTH = 4101,
  parameter int AW    = 13
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [imgconv_pkg::PIX_W-1:0]  wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [imgconv_pkg::PIX_W-1:0]  rd_data
);

  logic [imgconv_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/imgconv_mod.sv
module imgconv_mod #(
  parameter int VW  = 21,
  parameter int DIV = 4101,
  parameter int AW  = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] value,
  output logic          done,
  output logic [AW-1:0] result
);

  localparam int MW = VW + 1;
  localparam int PW = VW + MW;
  localparam int XW = (VW > AW) ? VW + 1 : AW + 2;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << VW) / 64'(DIV));

  logic [VW-1:0] val_q;
  logic [PW-1:0] prod;
  logic [AW:0]   part;
  logic          s1;
  logic          s2;
  logic [MW-1:0] quot;
  logic [XW-1:0] diff;

  // The reciprocal estimate of the quotient is low by at most one, so the partial
  // remainder stays below twice the divisor and one compare and subtract finishes it.
  always_comb begin
    quot = MW'(prod >> VW);
    diff = XW'(val_q) - XW'(quot) * XW'(DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= start;
      s2   <= s1;
      done <= s2;
    end
    if (start) begin
      val_q <= value;
      prod  <= value * RECIP;
    end
    if (s1) begin
      part <= diff[AW:0];
    end
    if (s2) begin
      result <= (part >= (AW + 1)'(DIV)) ? AW'(part - (AW + 1)'(DIV)) : part[AW-1:0];
    end
  end

endmodule

FILE: rtl/imgconv_scale.sv
module imgconv_scale (
  input  logic                                      clk,
  input  logic                                      rst,
  input  imgconv_pkg::scale_req_t                   req,
  input  logic signed [imgconv_pkg::SCALE_W-1:0]    scale,
  input  logic signed [imgconv_pkg::OFFS_W-1:0]     offset,
  output logic                                      res_valid,
  output logic [imgconv_pkg::CH_W-1:0]              res
);

  localparam int PW = imgconv_pkg::ACC_W + imgconv_pkg::SCALE_W;
  localparam int TW = PW + 1;

  logic                             p_valid;
  logic signed [PW-1:0]             prod;
  logic [imgconv_pkg::CH_W-1:0]     maxv_q;
  logic signed [TW-1:0]             prod_x;
  logic signed [TW-1:0]             offs_x;
  logic signed [TW-1:0]             sum;
  logic signed [TW-1:0]             biased;
  logic signed [TW-1:0]             v;
  logic [imgconv_pkg::CH_W-1:0]     clamped;

  always_comb begin
    prod_x = prod;
    offs_x = offset;
    sum    = prod_x + (offs_x <<< imgconv_pkg::FRAC_W);
    // Bias negative values so that the arithmetic shift truncates toward zero.
    biased = sum + (sum[TW-1] ? TW'((1 << imgconv_pkg::FRAC_W) - 1) : TW'(0));
    v      = biased >>> imgconv_pkg::FRAC_W;
    if (v < 0) begin
      clamped = '0;
    end else if (v > $signed({1'b0, TW'(maxv_q)})) begin
      clamped = maxv_q;
    end else begin
      clamped = v[imgconv_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p_valid   <= req.valid;
      res_valid <= p_valid;
    end
    prod   <= req.acc * scale;
    maxv_q <= req.maxv;
    res    <= clamped;
  end

endmodule
